// ----- hw/rtl/scp_pkg.sv -----
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, codes and helpers for the script container parser.
// ----------------------------------------------------------------------------
package scp_pkg;

    // Varint record length: bytes allowed per length field
    localparam int MAX_LEN_BYTES = 2;
    localparam int LEN_W         = 7 * MAX_LEN_BYTES;
    localparam int LCNT_W        = $clog2(MAX_LEN_BYTES + 1);

    // Field widths
    localparam int DLEN_W  = 14;
    localparam int PCNT_W  = 17;
    localparam int STAT_W  = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 1;

    // Result group: up to four result transactions per input byte
    localparam int MAX_RES   = 4;
    localparam int RCNT_W    = $clog2(MAX_RES + 1);
    localparam int RIDX_W    = $clog2(MAX_RES);

    localparam logic [PCNT_W-1:0] PCNT_MAX  = '1;
    localparam logic [DLEN_W-1:0] DLEN_MAX  = '1;
    localparam logic [PCNT_W-1:0] MAGIC_END = PCNT_W'(4);
    localparam logic [PCNT_W-1:0] MIN_PCNT  = PCNT_W'(5);

    // Configuration register indexes and reset values
    localparam logic [CIDX_W-1:0] CFG_MAGIC_CODE   = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MAGIC_SCRIPT = 1'b1;
    localparam logic [CFG_W-1:0]  MAGIC_CODE_RST   = 32'h5059_4344;
    localparam logic [CFG_W-1:0]  MAGIC_SCRIPT_RST = 32'h5059_5343;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SCRIPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 4'd0;
    localparam logic [STAT_W-1:0] ST_SHORT     = 4'd1;
    localparam logic [STAT_W-1:0] ST_LEN_MISM  = 4'd2;
    localparam logic [STAT_W-1:0] ST_BAD_MAGIC = 4'd3;
    localparam logic [STAT_W-1:0] ST_ZERO_LEN  = 4'd4;
    localparam logic [STAT_W-1:0] ST_LEN_LONG  = 4'd5;
    localparam logic [STAT_W-1:0] ST_CUT_LEN   = 4'd6;
    localparam logic [STAT_W-1:0] ST_REC_CUT   = 4'd7;
    localparam logic [STAT_W-1:0] ST_NO_TERM   = 4'd8;

    // Special byte values
    localparam logic [7:0] BYTE_LIST_END = 8'h00;
    localparam logic [7:0] BYTE_BOM0     = 8'hEF;
    localparam logic [7:0] BYTE_BOM1     = 8'hBB;
    localparam logic [7:0] BYTE_BOM2     = 8'hBF;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_LF       = 8'h0A;

    typedef enum logic [3:0] {
        PH_LEN_LO,
        PH_LEN_HI,
        PH_MAGIC,
        PH_META,
        PH_LENX,
        PH_TYPE,
        PH_DATA,
        PH_SCRIPT,
        PH_SINK
    } t_phase;

    typedef enum logic [1:0] {
        BOM_FIRST,
        BOM_GOT_EF,
        BOM_GOT_BB,
        BOM_DONE
    } t_bom;

    typedef struct packed {
        logic [KIND_W-1:0] out_kind;
        logic [7:0]        out_byte;
        logic [7:0]        record_type;
        logic [DLEN_W-1:0] record_data_length;
        logic              magic_is_script;
        logic [STAT_W-1:0] status;
        logic              end_of_run;
    } t_res;

    typedef struct packed {
        logic [RCNT_W-1:0]     cnt;
        t_res [MAX_RES-1:0]    item;
    } t_grp;

    // Build one result transaction with the unused fields at zero
    function automatic t_res mk_res(input logic [KIND_W-1:0] kind,
                                    input logic [7:0]        data,
                                    input logic [7:0]        rtype,
                                    input logic [DLEN_W-1:0] dlen);
        t_res r;
        r                    = '0;
        r.out_kind           = kind;
        r.out_byte           = data;
        r.record_type        = rtype;
        r.record_data_length = dlen;
        return r;
    endfunction

    // Clamp a record data length to the header field
    function automatic logic [DLEN_W-1:0] sat_dlen(input logic [LEN_W-1:0] v);
        logic [DLEN_W-1:0] r;
        if (LEN_W > DLEN_W && v > LEN_W'(DLEN_MAX)) begin
            r = DLEN_MAX;
        end else begin
            r = DLEN_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/scp_in_if.sv -----
// ----------------------------------------------------------------------------
// scp_in_if
// Input channel: one container byte per transaction.
// ----------------------------------------------------------------------------
interface scp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// ----- hw/rtl/scp_out_if.sv -----
// ----------------------------------------------------------------------------
// scp_out_if
// Output channel: one record, script or status item per transaction.
// ----------------------------------------------------------------------------
interface scp_out_if
    import scp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] out_kind;
    logic [7:0]        out_byte;
    logic [7:0]        record_type;
    logic [DLEN_W-1:0] record_data_length;
    logic              magic_is_script;
    logic [STAT_W-1:0] status;
    logic              end_of_run;

    modport source (output valid, output out_kind, output out_byte, output record_type,
                    output record_data_length, output magic_is_script, output status,
                    output end_of_run, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input record_type,
                    input record_data_length, input magic_is_script, input status,
                    input end_of_run, output ready);
endinterface

// ----- hw/rtl/scp_parse.sv -----
// ----------------------------------------------------------------------------
// scp_parse
// Parser state and per-byte decode: updates the container state for each
// accepted byte and builds the group of result items that byte causes.
// ----------------------------------------------------------------------------
module scp_parse
    import scp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic              i_is_last,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output t_grp              o_grp
);

    logic [CFG_W-1:0]  r_magic_code,  n_magic_code;
    logic [CFG_W-1:0]  r_magic_script, n_magic_script;

    t_phase            r_phase,   n_phase;
    logic [PCNT_W-1:0] r_pcount,  n_pcount;
    logic [15:0]       r_decl,    n_decl;
    logic [23:0]       r_magic,   n_magic;
    logic [LEN_W-1:0]  r_lpart,   n_lpart;
    logic [LCNT_W-1:0] r_lcnt,    n_lcnt;
    logic [LEN_W-1:0]  r_bleft,   n_bleft;
    t_bom              r_bom,     n_bom;
    logic              r_skip,    n_skip;
    logic [STAT_W-1:0] r_ferr,    n_ferr;
    logic              r_matched, n_matched;

    logic [PCNT_W-1:0] pc_inc;
    logic [CFG_W-1:0]  magic_word;
    logic [LEN_W-1:0]  bl;
    logic [RCNT_W-1:0] idx;
    logic              do_plain;
    logic              short_run;
    logic [STAT_W-1:0] st;
    t_grp              grp;

    // Configuration registers
    always_comb begin
        n_magic_code   = r_magic_code;
        n_magic_script = r_magic_script;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAGIC_CODE:   n_magic_code   = i_cfg_wdata;
                CFG_MAGIC_SCRIPT: n_magic_script = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_code   <= MAGIC_CODE_RST;
            r_magic_script <= MAGIC_SCRIPT_RST;
        end else begin
            r_magic_code   <= n_magic_code;
            r_magic_script <= n_magic_script;
        end
    end

    // Decode one byte: next state and the result group
    always_comb begin
        n_phase    = r_phase;
        n_pcount   = r_pcount;
        n_decl     = r_decl;
        n_magic    = r_magic;
        n_lpart    = r_lpart;
        n_lcnt     = r_lcnt;
        n_bleft    = r_bleft;
        n_bom      = r_bom;
        n_skip     = r_skip;
        n_ferr     = r_ferr;
        n_matched  = r_matched;
        grp        = '0;
        idx        = '0;
        do_plain   = 1'b0;
        short_run  = 1'b0;
        st         = ST_OK;
        bl         = r_lpart - LEN_W'(1);
        pc_inc     = (r_pcount != PCNT_MAX) ? r_pcount + PCNT_W'(1) : r_pcount;
        magic_word = {r_magic, i_data_byte};

        if (r_phase == PH_LEN_LO) begin
            n_decl  = {8'h00, i_data_byte};
            n_phase = PH_LEN_HI;
        end else if (r_phase == PH_LEN_HI) begin
            n_decl  = {i_data_byte, r_decl[7:0]};
            n_phase = PH_MAGIC;
        end else begin
            n_pcount = pc_inc;
            unique case (r_phase)
                // Collect the magic and match it against both registers
                PH_MAGIC: begin
                    n_magic = magic_word[23:0];
                    if (pc_inc >= MAGIC_END) begin
                        if (magic_word == r_magic_code) begin
                            n_matched = 1'b0;
                            n_phase   = PH_META;
                        end else if (magic_word == r_magic_script) begin
                            n_matched = 1'b1;
                            n_phase   = PH_META;
                        end else begin
                            if (n_ferr == ST_OK) n_ferr = ST_BAD_MAGIC;
                            n_phase = PH_SINK;
                        end
                    end
                end
                // First byte of a record length, or the list terminator
                PH_META: begin
                    if (i_data_byte == BYTE_LIST_END) begin
                        n_phase = PH_SCRIPT;
                    end else begin
                        n_lpart = LEN_W'(i_data_byte[6:0]);
                        n_lcnt  = LCNT_W'(1);
                        if (i_data_byte[7]) begin
                            if (MAX_LEN_BYTES <= 1) begin
                                if (n_ferr == ST_OK) n_ferr = ST_LEN_LONG;
                                n_phase = PH_SINK;
                            end else begin
                                n_phase = PH_LENX;
                            end
                        end else if (i_data_byte[6:0] == 7'd0) begin
                            if (n_ferr == ST_OK) n_ferr = ST_ZERO_LEN;
                            n_phase = PH_SINK;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
                // Further varint groups
                PH_LENX: begin
                    for (int k = 1; k < MAX_LEN_BYTES; k++) begin
                        if (r_lcnt == LCNT_W'(k)) n_lpart[7*k +: 7] = i_data_byte[6:0];
                    end
                    n_lcnt = r_lcnt + LCNT_W'(1);
                    if (i_data_byte[7]) begin
                        if (n_lcnt >= LCNT_W'(MAX_LEN_BYTES)) begin
                            if (n_ferr == ST_OK) n_ferr = ST_LEN_LONG;
                            n_phase = PH_SINK;
                        end
                    end else if (n_lpart == '0) begin
                        if (n_ferr == ST_OK) n_ferr = ST_ZERO_LEN;
                        n_phase = PH_SINK;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
                // Type byte: emit the record header
                PH_TYPE: begin
                    n_bleft = bl;
                    grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_HEADER, 8'h00, i_data_byte,
                                                       sat_dlen(bl));
                    idx     = idx + RCNT_W'(1);
                    n_phase = (bl != '0) ? PH_DATA : PH_META;
                end
                // Record data bytes
                PH_DATA: begin
                    grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_DATA, i_data_byte, 8'h00, '0);
                    idx     = idx + RCNT_W'(1);
                    n_bleft = r_bleft - LEN_W'(1);
                    if (n_bleft == '0) n_phase = PH_META;
                end
                // Script text: strip a leading byte-order mark
                PH_SCRIPT: begin
                    unique case (r_bom)
                        BOM_FIRST: begin
                            if (i_data_byte == BYTE_BOM0) begin
                                n_bom = BOM_GOT_EF;
                            end else begin
                                n_bom    = BOM_DONE;
                                do_plain = 1'b1;
                            end
                        end
                        BOM_GOT_EF: begin
                            if (i_data_byte == BYTE_BOM1) begin
                                n_bom = BOM_GOT_BB;
                            end else begin
                                grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_SCRIPT, BYTE_BOM0,
                                                                   8'h00, '0);
                                idx      = idx + RCNT_W'(1);
                                n_bom    = BOM_DONE;
                                do_plain = 1'b1;
                            end
                        end
                        BOM_GOT_BB: begin
                            n_bom = BOM_DONE;
                            if (i_data_byte != BYTE_BOM2) begin
                                grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_SCRIPT, BYTE_BOM0,
                                                                   8'h00, '0);
                                idx = idx + RCNT_W'(1);
                                grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_SCRIPT, BYTE_BOM1,
                                                                   8'h00, '0);
                                idx      = idx + RCNT_W'(1);
                                do_plain = 1'b1;
                            end
                        end
                        BOM_DONE: do_plain = 1'b1;
                        default: ;
                    endcase
                    // Line endings: CR and CR LF become LF
                    if (do_plain) begin
                        n_skip = 1'b0;
                        if (!(r_skip && i_data_byte == BYTE_LF)) begin
                            if (i_data_byte == BYTE_CR) begin
                                grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_SCRIPT, BYTE_LF,
                                                                   8'h00, '0);
                                n_skip = 1'b1;
                            end else begin
                                grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_SCRIPT, i_data_byte,
                                                                   8'h00, '0);
                            end
                            idx = idx + RCNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        // Last byte: close the container and report the status
        if (i_is_last) begin
            short_run = (n_phase == PH_LEN_LO) || (n_phase == PH_LEN_HI) ||
                        (n_phase == PH_MAGIC) || (n_pcount < MIN_PCNT);
            if (!short_run) begin
                unique case (n_phase)
                    PH_META: begin
                        if (n_ferr == ST_OK) n_ferr = ST_NO_TERM;
                    end
                    PH_LENX: begin
                        if (n_ferr == ST_OK) n_ferr = ST_CUT_LEN;
                    end
                    PH_TYPE, PH_DATA: begin
                        if (n_ferr == ST_OK) n_ferr = ST_REC_CUT;
                    end
                    PH_SCRIPT: begin
                        if (n_bom == BOM_GOT_EF || n_bom == BOM_GOT_BB) begin
                            grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_SCRIPT, BYTE_BOM0,
                                                               8'h00, '0);
                            idx = idx + RCNT_W'(1);
                        end
                        if (n_bom == BOM_GOT_BB) begin
                            grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_SCRIPT, BYTE_BOM1,
                                                               8'h00, '0);
                            idx = idx + RCNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (short_run) begin
                st = ST_SHORT;
            end else if (n_pcount != {1'b0, n_decl}) begin
                st = ST_LEN_MISM;
            end else begin
                st = n_ferr;
            end
            grp.item[idx[RIDX_W-1:0]] = mk_res(KIND_STATUS, 8'h00, 8'h00, '0);
            grp.item[idx[RIDX_W-1:0]].magic_is_script = !short_run && n_matched;
            grp.item[idx[RIDX_W-1:0]].status          = st;
            idx = idx + RCNT_W'(1);

            // Return to the start of a new container
            n_phase   = PH_LEN_LO;
            n_pcount  = '0;
            n_decl    = '0;
            n_magic   = '0;
            n_lpart   = '0;
            n_lcnt    = '0;
            n_bleft   = '0;
            n_bom     = BOM_FIRST;
            n_skip    = 1'b0;
            n_ferr    = ST_OK;
            n_matched = 1'b0;
        end

        // Flag the final item of the group
        if (idx != '0) begin
            grp.item[RIDX_W'(idx - RCNT_W'(1))].end_of_run = 1'b1;
        end
        grp.cnt = idx;
    end

    assign o_grp = grp;

    // Advance parser state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN_LO;
            r_pcount  <= '0;
            r_decl    <= '0;
            r_magic   <= '0;
            r_lpart   <= '0;
            r_lcnt    <= '0;
            r_bleft   <= '0;
            r_bom     <= BOM_FIRST;
            r_skip    <= 1'b0;
            r_ferr    <= ST_OK;
            r_matched <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_pcount  <= n_pcount;
            r_decl    <= n_decl;
            r_magic   <= n_magic;
            r_lpart   <= n_lpart;
            r_lcnt    <= n_lcnt;
            r_bleft   <= n_bleft;
            r_bom     <= n_bom;
            r_skip    <= n_skip;
            r_ferr    <= n_ferr;
            r_matched <= n_matched;
        end
    end

endmodule

// ----- hw/rtl/scp_outq.sv -----
// ----------------------------------------------------------------------------
// scp_outq
// Result register: holds the group of items from one input transaction and
// hands them out one per output transaction.
// ----------------------------------------------------------------------------
module scp_outq
    import scp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_grp i_grp,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_take,
    output logic o_out_valid,
    output t_res o_head
);

    logic [RCNT_W-1:0]  r_cnt;
    t_res [MAX_RES-1:0] r_item;
    logic               pop;

    // Accept when empty or when the last held item leaves this cycle
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_cnt == '0) || (r_cnt == RCNT_W'(1) && i_out_ready);
    assign o_take      = i_in_valid && o_in_ready;
    assign o_head      = r_item[0];

    // Hold the item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_take) begin
            r_cnt <= i_grp.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - RCNT_W'(1);
        end
    end

    // Load a new group or shift the held items down
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_grp.item;
        end else if (pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_item[k] <= r_item[k+1];
            end
        end
    end

endmodule

// ----- hw/rtl/script_container_parser_unit.sv -----
// ----------------------------------------------------------------------------
// script_container_parser_unit
// Parses a stored script container byte by byte and emits record headers,
// record data, normalized script bytes and a final status item.
// ----------------------------------------------------------------------------
//
//  Channel     Dir   Handshake      Transaction
//  i_in_ch     in    valid/ready    one container byte, is_last on the final
//  o_out_ch    out   valid/ready    one result item (kind, bytes, status)
//  i_cfg_*     in    write enable   magic register write, no read-back
//
//  A byte is decoded in the cycle it is accepted; its results (zero to four
//  items) are visible from the next cycle, one item per cycle while the
//  output is ready. One byte per cycle is sustained while each byte yields
//  at most one item and the output is ready; a byte with more items holds
//  the input until its last item leaves the single output register group.
//  Reset is synchronous, active low, and returns the parser to the start of
//  a container with the magic registers at their defaults.
//  A stalled output holds its item; the input accepts while the last held
//  item leaves.
//
module script_container_parser_unit
    import scp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    scp_in_if.sink            i_in_ch,
    scp_out_if.source         o_out_ch,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    t_grp grp;
    t_res head;
    logic take;
    logic in_ready;
    logic out_valid;

    scp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_in_ch.data_byte),
        .i_is_last   (i_in_ch.is_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_grp       (grp)
    );

    scp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (grp),
        .i_in_valid  (i_in_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_in_ready  (in_ready),
        .o_take      (take),
        .o_out_valid (out_valid),
        .o_head      (head)
    );

    // Drive the channel ports
    assign i_in_ch.ready               = in_ready;
    assign o_out_ch.valid              = out_valid;
    assign o_out_ch.out_kind           = head.out_kind;
    assign o_out_ch.out_byte           = head.out_byte;
    assign o_out_ch.record_type        = head.record_type;
    assign o_out_ch.record_data_length = head.record_data_length;
    assign o_out_ch.magic_is_script    = head.magic_is_script;
    assign o_out_ch.status             = head.status;
    assign o_out_ch.end_of_run         = head.end_of_run;

endmodule

// ----- hw/rtl/scp_checker.sv -----
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the script container parser, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker
    import scp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_in_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [KIND_W-1:0] i_out_kind,
    input  logic [7:0]        i_out_byte,
    input  logic [STAT_W-1:0] i_out_status,
    input  logic              i_out_mis,
    input  logic              i_out_eor
);

    // Stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_byte) && $stable(i_out_status))
        else $error("output item changed while stalled");

    // The final byte of a container always produces an item next cycle
    a_last_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("no result after final byte");

    // Status closes the run of items for its byte
    a_status_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_STATUS |-> i_out_eor)
        else $error("status item without end of run");

    // Only status items carry status or magic flags
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_STATUS |-> i_out_status == ST_OK && !i_out_mis)
        else $error("status fields set on a non-status item");

    // Status codes stay in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_STATUS |-> i_out_status <= ST_NO_TERM)
        else $error("status code out of range");

endmodule

bind script_container_parser_unit scp_checker u_scp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_in_last    (i_in_ch.is_last),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_kind   (o_out_ch.out_kind),
    .i_out_byte   (o_out_ch.out_byte),
    .i_out_status (o_out_ch.status),
    .i_out_mis    (o_out_ch.magic_is_script),
    .i_out_eor    (o_out_ch.end_of_run)
);

// ----- tb/sv/script_container_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_container_parser_unit_tb
// Self-checking bench for the script container parser. A short table of
// containers with hand-typed final status comes first. Random containers
// follow under several magic settings. Each result transaction is compared
// field by field against a behavioral parser kept inside the bench.
// ----------------------------------------------------------------------------
module script_container_parser_unit_tb;
    import scp_pkg::*;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int HOLD_CYCLES      = 80;
    localparam int N_ROWS           = 29;

    // Directed row: one container byte, plus a typed final status where pinned
    typedef struct packed {
        logic [7:0]        b;
        logic              last;
        logic              pinned;
        logic [STAT_W-1:0] st;
        logic              mis;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_wdata;

    scp_in_if  in_ch ();
    scp_out_if out_ch ();

    script_container_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Short container, bad magic, script magic with a record and a held
    // partial byte-order mark, and a record length with too many bytes
    t_row stim_rows [N_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, ST_SHORT, 1'b0},
        '{8'h05, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h00, 1'b1, 1'b1, ST_BAD_MAGIC, 1'b0},
        '{8'h0B, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h50, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h59, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h53, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h43, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h03, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h80, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'hEF, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'hBB, 1'b1, 1'b1, ST_OK, 1'b1},
        '{8'h06, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h50, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h59, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h43, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h44, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h80, 1'b0, 1'b0, ST_OK, 1'b0},
        '{8'h80, 1'b1, 1'b1, ST_LEN_LONG, 1'b0}
    };

    // Parser state mirrored in the bench
    t_phase            parse_phase;
    logic [PCNT_W-1:0] pay_cnt;
    logic [15:0]       decl_len;
    logic [31:0]       magic_acc;
    logic [31:0]       rec_len;
    int                len_bytes;
    logic [31:0]       data_left;
    t_bom              bom_state;
    logic              skip_lf;
    logic [STAT_W-1:0] first_err;
    logic              is_script;
    logic [CFG_W-1:0]  cfg_code;
    logic [CFG_W-1:0]  cfg_script;

    t_res       step_items [$];
    t_res       expected_items [$];
    logic [7:0] frame_q [$];

    int         err_cnt = 0;
    int         n_bytes_in = 0;
    int         n_checked = 0;
    int         n_frames = 0;
    int         idle_cycles = 0;
    logic [8:0] status_seen = '0;
    bit         send_idle = 1'b1;
    bit         sink_idle = 1'b1;
    bit         hold_pending = 1'b0;
    t_res       exp_r;

    // ------------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------------
    task automatic clear_parse();
        parse_phase = PH_LEN_LO;
        pay_cnt     = '0;
        decl_len    = '0;
        magic_acc   = '0;
        rec_len     = '0;
        len_bytes   = 0;
        data_left   = '0;
        bom_state   = BOM_FIRST;
        skip_lf     = 1'b0;
        first_err   = ST_OK;
        is_script   = 1'b0;
    endtask

    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [7:0] b,
                             input logic [7:0] rtype, input logic [31:0] dlen,
                             input logic mis, input logic [STAT_W-1:0] st);
        t_res r;
        r                    = '0;
        r.out_kind           = kind;
        r.out_byte           = b;
        r.record_type        = rtype;
        r.record_data_length = (dlen > 32'(DLEN_MAX)) ? DLEN_MAX : dlen[DLEN_W-1:0];
        r.magic_is_script    = mis;
        r.status             = st;
        step_items = {step_items, r};
    endtask

    // Keep only the first error and drop everything up to the last byte
    task automatic flag_error(input logic [STAT_W-1:0] st);
        if (first_err == ST_OK) begin
            first_err = st;
        end
        parse_phase = PH_SINK;
    endtask

    // Turn CR and CR LF into LF
    task automatic emit_script_char(input logic [7:0] b);
        if (skip_lf) begin
            skip_lf = 1'b0;
            if (b == BYTE_LF) begin
                return;
            end
        end
        if (b == BYTE_CR) begin
            push_item(KIND_SCRIPT, BYTE_LF, 8'h00, 0, 1'b0, ST_OK);
            skip_lf = 1'b1;
        end else begin
            push_item(KIND_SCRIPT, b, 8'h00, 0, 1'b0, ST_OK);
        end
    endtask

    // Strip a leading byte-order mark, release a partial one as plain bytes
    task automatic take_script_byte(input logic [7:0] b);
        case (bom_state)
            BOM_FIRST: begin
                if (b == BYTE_BOM0) begin
                    bom_state = BOM_GOT_EF;
                    return;
                end
            end
            BOM_GOT_EF: begin
                if (b == BYTE_BOM1) begin
                    bom_state = BOM_GOT_BB;
                    return;
                end
                push_item(KIND_SCRIPT, BYTE_BOM0, 8'h00, 0, 1'b0, ST_OK);
            end
            BOM_GOT_BB: begin
                bom_state = BOM_DONE;
                if (b == BYTE_BOM2) begin
                    return;
                end
                push_item(KIND_SCRIPT, BYTE_BOM0, 8'h00, 0, 1'b0, ST_OK);
                push_item(KIND_SCRIPT, BYTE_BOM1, 8'h00, 0, 1'b0, ST_OK);
            end
            default: ;
        endcase
        bom_state = BOM_DONE;
        emit_script_char(b);
    endtask

    task automatic close_record_length();
        if (rec_len == 0) begin
            flag_error(ST_ZERO_LEN);
        end else begin
            parse_phase = PH_TYPE;
        end
    endtask

    // Metadata list: varint length, type byte, data bytes, zero terminator
    task automatic take_record_byte(input logic [7:0] b);
        int shift;
        case (parse_phase)
            PH_META: begin
                if (b == BYTE_LIST_END) begin
                    parse_phase = PH_SCRIPT;
                end else begin
                    rec_len   = 32'(b[6:0]);
                    len_bytes = 1;
                    if (b[7]) begin
                        if (len_bytes >= MAX_LEN_BYTES) begin
                            flag_error(ST_LEN_LONG);
                        end else begin
                            parse_phase = PH_LENX;
                        end
                    end else begin
                        close_record_length();
                    end
                end
            end
            PH_LENX: begin
                shift = 7 * len_bytes;
                if (shift < 32) begin
                    rec_len = rec_len | (32'(b[6:0]) << shift);
                end
                len_bytes++;
                if (b[7]) begin
                    if (len_bytes >= MAX_LEN_BYTES) begin
                        flag_error(ST_LEN_LONG);
                    end
                end else begin
                    close_record_length();
                end
            end
            PH_TYPE: begin
                data_left = rec_len - 1;
                push_item(KIND_HEADER, 8'h00, b, data_left, 1'b0, ST_OK);
                if (data_left != 0) begin
                    parse_phase = PH_DATA;
                end else begin
                    parse_phase = PH_META;
                end
            end
            PH_DATA: begin
                push_item(KIND_DATA, b, 8'h00, 0, 1'b0, ST_OK);
                data_left = data_left - 1;
                if (data_left == 0) begin
                    parse_phase = PH_META;
                end
            end
            default: ;
        endcase
    endtask

    // Advance the parser by one byte and queue the results it causes
    task automatic parse_container_byte(input logic [7:0] b, input logic last);
        logic              short_run;
        logic [STAT_W-1:0] st;
        t_res              r;
        step_items.delete();
        if (parse_phase == PH_LEN_LO) begin
            decl_len    = {8'h00, b};
            parse_phase = PH_LEN_HI;
        end else if (parse_phase == PH_LEN_HI) begin
            decl_len[15:8] = b;
            parse_phase    = PH_MAGIC;
        end else begin
            if (pay_cnt != PCNT_MAX) begin
                pay_cnt = pay_cnt + PCNT_W'(1);
            end
            if (parse_phase == PH_MAGIC) begin
                magic_acc = {magic_acc[23:0], b};
                if (pay_cnt >= MAGIC_END) begin
                    if (magic_acc == cfg_code) begin
                        is_script   = 1'b0;
                        parse_phase = PH_META;
                    end else if (magic_acc == cfg_script) begin
                        is_script   = 1'b1;
                        parse_phase = PH_META;
                    end else begin
                        flag_error(ST_BAD_MAGIC);
                    end
                end
            end else if (parse_phase == PH_SCRIPT) begin
                take_script_byte(b);
            end else if (parse_phase != PH_SINK) begin
                take_record_byte(b);
            end
        end

        // Close the container: flush held bytes, pick the status by priority
        if (last) begin
            short_run = (parse_phase == PH_LEN_LO) || (parse_phase == PH_LEN_HI) ||
                        (parse_phase == PH_MAGIC) || (pay_cnt < MIN_PCNT);
            if (!short_run) begin
                if (parse_phase == PH_META) begin
                    flag_error(ST_NO_TERM);
                end else if (parse_phase == PH_LENX) begin
                    flag_error(ST_CUT_LEN);
                end else if (parse_phase == PH_TYPE || parse_phase == PH_DATA) begin
                    flag_error(ST_REC_CUT);
                end else if (parse_phase == PH_SCRIPT) begin
                    if (bom_state == BOM_GOT_EF || bom_state == BOM_GOT_BB) begin
                        push_item(KIND_SCRIPT, BYTE_BOM0, 8'h00, 0, 1'b0, ST_OK);
                    end
                    if (bom_state == BOM_GOT_BB) begin
                        push_item(KIND_SCRIPT, BYTE_BOM1, 8'h00, 0, 1'b0, ST_OK);
                    end
                end
            end
            if (short_run) begin
                st = ST_SHORT;
            end else if (pay_cnt != {1'b0, decl_len}) begin
                st = ST_LEN_MISM;
            end else begin
                st = first_err;
            end
            push_item(KIND_STATUS, 8'h00, 8'h00, 0, !short_run && is_script, st);
            clear_parse();
        end

        foreach (step_items[i]) begin
            r            = step_items[i];
            r.end_of_run = (i == step_items.size() - 1);
            expected_items = {expected_items, r};
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Offer one byte, predict at acceptance, then maybe idle for a burst.
    // A pinned row replaces the predicted status with the typed one.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                             input logic [STAT_W-1:0] st, input logic mis);
        t_res r;
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.is_last   <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        n_bytes_in++;
        parse_container_byte(b, last);
        if (pinned) begin
            r                 = '0;
            r.out_kind        = KIND_STATUS;
            r.magic_is_script = mis;
            r.status          = st;
            r.end_of_run      = 1'b1;
            expected_items[expected_items.size() - 1] = r;
        end
        if (last) begin
            n_frames++;
        end
        if (send_idle && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every expected result plus a short margin
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both magic registers on back-to-back cycles
    task automatic set_magics(input logic [CFG_W-1:0] code, input logic [CFG_W-1:0] scr);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MAGIC_CODE;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MAGIC_SCRIPT;
        i_cfg_wdata <= scr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_code     = code;
        cfg_script   = scr;
    endtask

    // Build one container: mostly well formed with random content,
    // sometimes broken records, cut payloads, wrong lengths or pure noise
    task automatic build_frame();
        logic [7:0]  pay [$];
        logic [31:0] m;
        logic [15:0] decl;
        int          k;
        int          dl;
        int          reclen;
        int          cut;
        frame_q.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 12)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
            return;
        end
        case ($urandom_range(0, 9))
            0:             m = $urandom;
            1, 2, 3, 4, 5: m = cfg_code;
            default:       m = cfg_script;
        endcase
        for (k = 3; k >= 0; k--) begin
            pay = {pay, m[8*k +: 8]};
        end
        repeat ($urandom_range(0, 3)) begin
            dl     = ($urandom_range(0, 19) == 0) ? $urandom_range(127, 140)
                                                  : $urandom_range(0, 6);
            reclen = dl + 1;
            if (reclen < 128 && $urandom_range(0, 3) != 0) begin
                pay = {pay, 8'(reclen)};
            end else begin
                pay = {pay, {1'b1, 7'(reclen)}};
                pay = {pay, {1'b0, 7'(reclen >> 7)}};
            end
            pay = {pay, 8'($urandom_range(0, 255))};
            repeat (dl) pay = {pay, 8'($urandom_range(0, 255))};
        end
        case ($urandom_range(0, 19))
            0: begin
                pay = {pay, 8'h80};
                pay = {pay, 8'h00};
            end
            1: begin
                pay = {pay, 8'hFF};
                pay = {pay, 8'hFF};
            end
            default: ;
        endcase
        pay = {pay, BYTE_LIST_END};
        case ($urandom_range(0, 5))
            0: begin
                pay = {pay, BYTE_BOM0};
                pay = {pay, BYTE_BOM1};
                pay = {pay, BYTE_BOM2};
            end
            1: pay = {pay, BYTE_BOM0};
            2: begin
                pay = {pay, BYTE_BOM0};
                pay = {pay, BYTE_BOM1};
            end
            default: ;
        endcase
        repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 9))
                0:       pay = {pay, BYTE_CR};
                1:       pay = {pay, BYTE_LF};
                2:       pay = {pay, BYTE_BOM0};
                3:       pay = {pay, BYTE_BOM1};
                default: pay = {pay, 8'($urandom_range(0, 255))};
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(0, pay.size());
            while (pay.size() > cut) pay.delete(pay.size() - 1);
        end
        decl = 16'(pay.size());
        case ($urandom_range(0, 9))
            0:       decl = decl + 16'($urandom_range(1, 3));
            1:       decl = decl - 16'($urandom_range(1, 3));
            2:       decl = 16'($urandom);
            default: ;
        endcase
        frame_q = {frame_q, decl[7:0]};
        frame_q = {frame_q, decl[15:8]};
        foreach (pay[i]) frame_q = {frame_q, pay[i]};
    endtask

    task automatic random_frames(input int n_target);
        int start;
        start = n_bytes_in;
        while (n_bytes_in - start < n_target) begin
            build_frame();
            foreach (frame_q[i]) begin
                send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, ST_OK, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] v;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_MAGIC_CODE;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.is_last   <= 1'b0;
        cfg_code   = MAGIC_CODE_RST;
        cfg_script = MAGIC_SCRIPT_RST;
        clear_parse();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the default magics
        foreach (stim_rows[i]) begin
            send_byte(stim_rows[i].b, stim_rows[i].last, stim_rows[i].pinned,
                      stim_rows[i].st, stim_rows[i].mis);
        end
        drain();

        // Extreme magics, with one long output stall to back up the input
        set_magics('1, '0);
        hold_pending = 1'b1;
        random_frames(90);
        drain();

        // Both magics equal, no idling on either side
        v = $urandom;
        set_magics(v, v);
        send_idle = 1'b0;
        sink_idle = 1'b0;
        random_frames(60);
        drain();

        // Random magics, idling back on
        set_magics($urandom, $urandom);
        send_idle = 1'b1;
        sink_idle = 1'b1;
        random_frames(90);
        drain();

        // Defaults again, full rate to the end
        set_magics(MAGIC_CODE_RST, MAGIC_SCRIPT_RST);
        send_idle = 1'b0;
        sink_idle = 1'b0;
        random_frames(30);
        drain();

        $display("Run summary: %0d containers, %0d bytes accepted, %0d results checked",
                 n_frames, n_bytes_in, n_checked);
        $display("Status codes reported (bit per code, 8 down to 0): %09b", status_seen);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls and one long hold
    // ------------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_items.size() == 0) begin
                $error("unexpected result transaction: kind %0d byte %02h status %0d",
                       out_ch.out_kind, out_ch.out_byte, out_ch.status);
                err_cnt++;
            end else begin
                exp_r = expected_items.pop_front();
                n_checked++;
                if (out_ch.out_kind !== exp_r.out_kind) begin
                    $error("out_kind mismatch: expected %0d, got %0d",
                           exp_r.out_kind, out_ch.out_kind);
                    err_cnt++;
                end
                if (out_ch.out_byte !== exp_r.out_byte) begin
                    $error("out_byte mismatch: expected %02h, got %02h",
                           exp_r.out_byte, out_ch.out_byte);
                    err_cnt++;
                end
                if (out_ch.record_type !== exp_r.record_type) begin
                    $error("record_type mismatch: expected %02h, got %02h",
                           exp_r.record_type, out_ch.record_type);
                    err_cnt++;
                end
                if (out_ch.record_data_length !== exp_r.record_data_length) begin
                    $error("record_data_length mismatch: expected %0d, got %0d",
                           exp_r.record_data_length, out_ch.record_data_length);
                    err_cnt++;
                end
                if (out_ch.magic_is_script !== exp_r.magic_is_script) begin
                    $error("magic_is_script mismatch: expected %0d, got %0d",
                           exp_r.magic_is_script, out_ch.magic_is_script);
                    err_cnt++;
                end
                if (out_ch.status !== exp_r.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           exp_r.status, out_ch.status);
                    err_cnt++;
                end
                if (out_ch.end_of_run !== exp_r.end_of_run) begin
                    $error("end_of_run mismatch: expected %0d, got %0d",
                           exp_r.end_of_run, out_ch.end_of_run);
                    err_cnt++;
                end
                if (exp_r.out_kind == KIND_STATUS && exp_r.status <= ST_NO_TERM) begin
                    status_seen[exp_r.status] = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles, %0d results still expected",
                   idle_cycles, expected_items.size());
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
